// ===== sv/wimm_pkg.sv =====
// Shared types and constants for the weighted image match merit block.
`timescale 1ns / 1ps
`default_nettype none
package wimm_pkg;

    localparam int unsigned ACC_W      = 56;
    localparam int unsigned PROD_W     = 2 * ACC_W;
    localparam int unsigned RATIO_FRAC = 18;
    localparam int unsigned Q_W        = RATIO_FRAC + 1;
    localparam int unsigned NUM_PLANES = 3;

    localparam logic [Q_W-1:0] RATIO_ONE  = Q_W'(1) << RATIO_FRAC;
    // 3 * 2^18 + 6: one minus the mean, with rounding bias, scaled by 12
    localparam logic [19:0]    MERIT_BIAS = 20'd786438;
    // ceil(2^19 / 3), exact divide by three for values below 2^19
    localparam logic [17:0]    RECIP3     = 18'd174763;
    localparam int unsigned    RECIP3_SHIFT = 19;

    typedef struct packed {
        logic           done;    // lane finished the current word
        logic           result;  // word closed a frame, q and degen valid
        logic           degen;   // zero denominator in this plane
        logic [Q_W-1:0] q;       // plane ratio, Q1.18
    } t_lane_stat;

endpackage
`default_nettype wire

// ===== sv/weighted_image_match_merit.sv =====
// Top level: weighted normalized cross-correlation merit over three planes.
//
// Input stream (s_axis): one word per pixel position. tdata carries the
// measured, target and weight pixels of planes A, B and C; tlast marks the
// last pixel of a frame. Output stream (m_axis): one word per frame, tdata
// is the merit (one minus the mean squared correlation, unsigned Q0.16,
// saturated) and tuser flags a plane with a zero energy sum.
//
// Three lanes, one per plane, accumulate their sums side by side; a merge
// stage averages the lane ratios.
// A pixel without tlast is multiplied and accumulated, then the block is ready
// again. A tlast pixel is accumulated and loaded, then every lane forms two
// 56 x 56 products by shift-add, does a compare and an 18 bit restoring
// division; the lanes hand off to the control, the merge runs, the output
// register loads and the block is ready again.
// The output register parts the two sides: new pixels are taken while a
// merit word waits. If that word is still stalled when the next frame
// ends, the block holds the new result and takes no pixel until it moves.
// Reset (synchronous, active low) clears all sums and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module weighted_image_match_merit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // image_a, image_b, image_c, target_a, target_b, target_c,
    // weight_a, weight_b, weight_c (lowest bit up)
    input  wire  [119:0] s_axis_tdata,
    input  wire          s_axis_tlast,   // frame_end
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [15:0]  m_axis_tdata,   // merit_value
    output logic         m_axis_tuser    // degenerate
);
    import wimm_pkg::*;

    typedef enum logic [1:0] {T_IDLE, T_LANE, T_MERGE, T_OUT} t_tstate;

    t_tstate           r_state;
    logic              r_out_valid;
    logic [15:0]       r_out_merit;
    logic              r_out_degen;
    t_lane_stat [2:0]  lane_stat;
    logic              accept;
    logic              merge_start;
    logic [15:0]       merge_merit;
    logic              merge_degen;
    logic              merge_done;
    logic              out_load;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign merge_start = lane_stat[0].done && lane_stat[0].result;
    // output register takes the merit when empty or being drained
    assign out_load    = (r_state == T_OUT) && (!r_out_valid || m_axis_tready);

    genvar g;
    generate
        for (g = 0; g < NUM_PLANES; g++) begin : g_lane
            wimm_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_start  (accept),
                .i_image  ($signed(s_axis_tdata[16*g +: 16])),
                .i_target (s_axis_tdata[48 + 16*g +: 16]),
                .i_weight (s_axis_tdata[96 + 8*g +: 8]),
                .i_last   (s_axis_tlast),
                .o_stat   (lane_stat[g])
            );
        end
    endgenerate

    wimm_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (merge_start),
        .i_stat  (lane_stat),
        .o_merit (merge_merit),
        .o_degen (merge_degen),
        .o_done  (merge_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
            case (r_state)
                T_IDLE: begin
                    if (accept) r_state <= T_LANE;
                end
                T_LANE: begin
                    // lanes run in lockstep; lane A speaks for all
                    if (lane_stat[0].done)
                        r_state <= lane_stat[0].result ? T_MERGE : T_IDLE;
                end
                T_MERGE: begin
                    if (merge_done) r_state <= T_OUT;
                end
                T_OUT: begin
                    if (out_load) begin
                        r_out_merit <= merge_merit;
                        r_out_degen <= merge_degen;
                        r_state     <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == T_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_merit;
    assign m_axis_tuser  = r_out_degen;

    // lanes must finish together
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lane_stat[0].done == lane_stat[1].done) &&
        (lane_stat[0].done == lane_stat[2].done))
        else $error("lanes out of step");

    // merge result only while the controller waits for it
    a_merge_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        merge_done |-> (r_state == T_MERGE))
        else $error("merge finished outside merge state");

    // a stalled output word is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_merit)))
        else $error("output word lost");

    // no pixel taken while a lane is busy
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("pixel accepted while lanes busy");

endmodule
`default_nettype wire

// ===== sv/wimm_lane.sv =====
// One plane: weighted sums, then squared correlation ratio at frame end.
`timescale 1ns / 1ps
`default_nettype none
module wimm_lane (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire  signed [15:0]       i_image,
    input  wire         [15:0]       i_target,
    input  wire         [7:0]        i_weight,
    input  wire                      i_last,
    output wimm_pkg::t_lane_stat     o_stat
);
    import wimm_pkg::*;

    typedef enum logic [2:0] {
        L_IDLE, L_ACC, L_LOAD, L_MUL, L_CMP, L_DIV
    } t_lstate;

    t_lstate             r_state;
    logic signed [24:0]  r_wi;
    logic        [23:0]  r_wt;
    logic signed [15:0]  r_img;
    logic        [15:0]  r_tgt;
    logic                r_last;
    logic [ACC_W-1:0]    r_cross, r_ie, r_te;
    logic [PROD_W-1:0]   r_mcn, r_mcd, r_den;
    logic [ACC_W-1:0]    r_mpn, r_mpd;
    logic [PROD_W:0]     r_num;
    logic [5:0]          r_cnt;
    logic                r_degen;
    logic                r_sat;
    logic [Q_W-1:0]      r_q;
    t_lane_stat          r_stat;

    logic signed [41:0]  p_cross;
    logic signed [40:0]  p_ie;
    logic        [39:0]  p_te;
    logic [ACC_W-1:0]    n_cross, n_ie, n_te, mag;
    logic [PROD_W:0]     n_shift;
    logic                div_ge;

    always_comb begin
        p_cross = r_wi * $signed({1'b0, r_tgt});
        p_ie    = r_wi * r_img;
        p_te    = r_wt * r_tgt;
        n_cross = r_cross + {{(ACC_W-42){p_cross[41]}}, p_cross};
        n_ie    = r_ie + {{(ACC_W-41){1'b0}}, p_ie};
        n_te    = r_te + {{(ACC_W-40){1'b0}}, p_te};
        mag     = r_cross[ACC_W-1] ? (~r_cross + 1'b1) : r_cross;
        n_shift = {r_num[PROD_W-1:0], 1'b0};
        div_ge  = n_shift >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= L_IDLE;
            r_cross  <= '0;
            r_ie     <= '0;
            r_te     <= '0;
            r_stat   <= '0;
        end else begin
            case (r_state)
                L_IDLE: begin
                    r_stat.done <= 1'b0;
                    if (i_start) begin
                        r_wi    <= $signed({1'b0, i_weight}) * i_image;
                        r_wt    <= i_weight * i_target;
                        r_img   <= i_image;
                        r_tgt   <= i_target;
                        r_last  <= i_last;
                        r_state <= L_ACC;
                    end
                end
                L_ACC: begin
                    r_cross <= n_cross;
                    r_ie    <= n_ie;
                    r_te    <= n_te;
                    if (r_last) begin
                        r_stat.done <= 1'b0;
                        r_state     <= L_LOAD;
                    end else begin
                        r_stat.done   <= 1'b1;
                        r_stat.result <= 1'b0;
                        r_state       <= L_IDLE;
                    end
                end
                L_LOAD: begin
                    r_stat.done <= 1'b0;
                    r_mcn   <= {{ACC_W{1'b0}}, mag};
                    r_mpn   <= mag;
                    r_mcd   <= {{ACC_W{1'b0}}, r_ie};
                    r_mpd   <= r_te;
                    r_num   <= '0;
                    r_den   <= '0;
                    r_cnt   <= '0;
                    r_degen <= (r_ie == '0) || (r_te == '0);
                    r_cross <= '0;
                    r_ie    <= '0;
                    r_te    <= '0;
                    r_state <= L_MUL;
                end
                L_MUL: begin
                    // shift-add, one multiplier bit a cycle for both products
                    r_stat.done <= 1'b0;
                    if (r_mpn[0]) r_num <= r_num + {1'b0, r_mcn};
                    if (r_mpd[0]) r_den <= r_den + r_mcd;
                    r_mcn <= r_mcn << 1;
                    r_mcd <= r_mcd << 1;
                    r_mpn <= r_mpn >> 1;
                    r_mpd <= r_mpd >> 1;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(ACC_W - 1)) r_state <= L_CMP;
                end
                L_CMP: begin
                    // always run the full divide so all lanes stay in step
                    r_stat.done <= 1'b0;
                    r_cnt   <= '0;
                    r_q     <= '0;
                    r_sat   <= r_num >= {1'b0, r_den};
                    r_state <= L_DIV;
                end
                L_DIV: begin
                    // restoring division, one quotient bit a cycle
                    r_num <= div_ge ? (n_shift - {1'b0, r_den}) : n_shift;
                    r_q   <= {r_q[Q_W-2:0], div_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(RATIO_FRAC - 1)) begin
                        r_stat.done   <= 1'b1;
                        r_stat.result <= 1'b1;
                        r_stat.degen  <= r_degen;
                        r_stat.q      <= r_degen ? '0 :
                                         r_sat   ? RATIO_ONE : {r_q[Q_W-2:0], div_ge};
                        r_state       <= L_IDLE;
                    end else begin
                        r_stat.done <= 1'b0;
                    end
                end
                default: begin
                    r_stat.done <= 1'b0;
                    r_state     <= L_IDLE;
                end
            endcase
        end
    end

    assign o_stat = r_stat;

endmodule
`default_nettype wire

// ===== sv/wimm_merge.sv =====
// Merges the three plane ratios into the merit value.
`timescale 1ns / 1ps
`default_nettype none
module wimm_merge (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wimm_pkg::t_lane_stat [2:0]       i_stat,
    output logic [15:0]                      o_merit,
    output logic                             o_degen,
    output logic                             o_done
);
    import wimm_pkg::*;

    logic [17:0] r_y;
    logic        r_deg;
    logic        r_stage1;
    logic [35:0] r_prod;
    logic        r_done;
    logic [19:0] sum;
    logic [19:0] diff;
    logic [16:0] quot;

    always_comb begin
        sum  = 20'(i_stat[0].q) + 20'(i_stat[1].q) + 20'(i_stat[2].q);
        diff = MERIT_BIAS - sum;
        quot = r_prod[RECIP3_SHIFT +: 17];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage1 <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_stage1 <= i_start;
            r_done   <= r_stage1;
            if (i_start) begin
                // divide by 12: drop two bits, then divide by three
                r_y   <= diff[19:2];
                r_deg <= i_stat[0].degen | i_stat[1].degen | i_stat[2].degen;
            end
            if (r_stage1) r_prod <= r_y * RECIP3;
        end
    end

    assign o_merit = quot[16] ? 16'hFFFF : quot[15:0];
    assign o_degen = r_deg;
    assign o_done  = r_done;

endmodule
`default_nettype wire

// ===== dv/weighted_image_match_merit_tb.sv =====
// Testbench for the weighted image match merit block: directed and random frames.
`timescale 1ns / 1ps
module weighted_image_match_merit_tb;
    import wimm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] merit;
        logic        degen;
    } t_merit;

    typedef struct {
        logic signed [15:0] img [3];
        logic [15:0]        tgt [3];
        logic [7:0]         wgt [3];
        logic               last;
    } t_pixel;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;   // image_a..c, target_a..c, weight_a..c
    logic         s_axis_tlast;   // frame_end
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;   // merit_value
    logic         m_axis_tuser;   // degenerate

    logic [55:0] cross_acc [3];
    logic [55:0] ienergy_acc [3];
    logic [55:0] tenergy_acc [3];
    t_merit      merit_queue [$];
    int          fail_count = 0;
    int          idle_cycles = 0;

    weighted_image_match_merit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // q = floor(2^18 * c^2 / (ie*te)), clamped to one
    function automatic logic [18:0] plane_ratio(input int p, inout logic degen);
        logic [55:0]  mag;
        logic [111:0] num, den;
        logic [129:0] scaled;
        if (ienergy_acc[p] == 0 || tenergy_acc[p] == 0) begin
            degen = 1'b1;
            return '0;
        end
        mag = cross_acc[p][55] ? (~cross_acc[p] + 56'd1) : cross_acc[p];
        num = mag * mag;
        den = ienergy_acc[p] * tenergy_acc[p];
        if (num >= den) return RATIO_ONE;
        scaled = {num, 18'd0};
        return 19'(scaled / den);
    endfunction

    function automatic void predict_pixel(input t_pixel px);
        logic signed [55:0] w, i, t;
        logic [20:0] sum;
        logic [20:0] mval;
        logic degen;
        for (int p = 0; p < 3; p++) begin
            w = {48'd0, px.wgt[p]};
            i = 56'(px.img[p]);
            t = {40'd0, px.tgt[p]};
            cross_acc[p]   += w * i * t;
            ienergy_acc[p] += w * i * i;
            tenergy_acc[p] += w * t * t;
        end
        if (!px.last) return;
        sum = 0;
        degen = 1'b0;
        for (int p = 0; p < 3; p++) sum += plane_ratio(p, degen);
        mval = (21'd786432 - sum + 21'd6) / 21'd12;
        if (mval > 65535) mval = 65535;
        merit_queue.push_back('{merit: mval[15:0], degen: degen});
        for (int p = 0; p < 3; p++) begin
            cross_acc[p] = 0; ienergy_acc[p] = 0; tenergy_acc[p] = 0;
        end
    endfunction

    // drives one pixel word and waits until it is taken
    task automatic send_pixel(input t_pixel px);
        int gap;
        gap = rand_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {px.wgt[2], px.wgt[1], px.wgt[0], px.tgt[2], px.tgt[1],
                          px.tgt[0], px.img[2], px.img[1], px.img[0]};
        s_axis_tlast  <= px.last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pixel(px);
    endtask

    function automatic t_pixel rand_pixel(input logic last, input int mode);
        t_pixel px;
        for (int p = 0; p < 3; p++) begin
            px.img[p] = 16'($urandom);
            px.tgt[p] = 16'($urandom);
            px.wgt[p] = 8'($urandom);
            if (mode == 1) px.tgt[p] = 16'(px.img[p]);   // well correlated
            if (mode == 2 && $urandom_range(0, 3) == 0) px.wgt[p] = 0;
        end
        px.last = last;
        return px;
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (merit_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic test_extremes();
        t_pixel px;
        // all zeros: every plane degenerate
        px = rand_pixel(1'b1, 0);
        for (int p = 0; p < 3; p++) begin
            px.img[p] = 0; px.tgt[p] = 0; px.wgt[p] = 0;
        end
        send_pixel(px);
        // full scale, perfectly correlated single pixel
        for (int p = 0; p < 3; p++) begin
            px.img[p] = 16'sh7fff; px.tgt[p] = 16'hffff; px.wgt[p] = 8'hff;
        end
        send_pixel(px);
        // most negative image
        for (int p = 0; p < 3; p++) begin
            px.img[p] = 16'sh8000; px.tgt[p] = 16'hffff; px.wgt[p] = 8'hff;
        end
        send_pixel(px);
        // one plane zero weight, others anticorrelated pair
        for (int k = 0; k < 2; k++) begin
            for (int p = 0; p < 3; p++) begin
                px.img[p] = k ? 16'sh0100 : -16'sh0100;
                px.tgt[p] = k ? 16'd5 : 16'd900;
                px.wgt[p] = (p == 1) ? 8'd0 : 8'd1 + 8'(k);
            end
            px.last = (k == 1);
            send_pixel(px);
        end
        // zero target energy only in plane C
        for (int k = 0; k < 4; k++) begin
            px = rand_pixel(k == 3, 0);
            px.tgt[2] = 0;
            send_pixel(px);
        end
        // single pixel frames of random content
        for (int k = 0; k < 6; k++) send_pixel(rand_pixel(1'b1, $urandom_range(0, 2)));
        wait_drained();
    endtask

    // large sums: long frame of full scale targets
    task automatic test_wrap();
        t_pixel px;
        for (int k = 0; k < 700; k++) begin
            for (int p = 0; p < 3; p++) begin
                px.img[p] = 16'sh7fff; px.tgt[p] = 16'hffff; px.wgt[p] = 8'hff;
            end
            px.last = (k == 699);
            send_pixel(px);
        end
        wait_drained();
    endtask

    task automatic test_random(input int n);
        int left, len;
        left = n;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            if (len > left) len = left;
            for (int k = 0; k < len; k++) send_pixel(rand_pixel(k == len - 1, $urandom_range(0, 2)));
            left -= len;
        end
        wait_drained();
    endtask

    // receiver with random stalls
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 99) < 60) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 3) == 0) ? 1'b0 : (rand_gap() == 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (merit_queue.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata, -1);
            end else begin
                t_merit want;
                want = merit_queue.pop_front();
                if (m_axis_tdata !== want.merit) report_mismatch("merit", m_axis_tdata, want.merit);
                if (m_axis_tuser !== want.degen) report_mismatch("degenerate", m_axis_tuser, want.degen);
            end
        end
    end

    // watchdog on cycles with no accepted word on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        for (int p = 0; p < 3; p++) begin
            cross_acc[p] = 0; ienergy_acc[p] = 0; tenergy_acc[p] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_wrap();
        test_random(1150);
        if (fail_count == 0 && merit_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
